// ===== rtl/tip_pkg.sv =====
package tip_pkg;

  // Largest tile row the row store holds
  localparam int TIP_MAX_TILE_WIDTH = 256;

  localparam int SAMPLE_W = 16;
  localparam int CODE_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [SAMPLE_W-1:0] MASK8  = 16'h00FF;
  localparam logic [SAMPLE_W-1:0] MASK16 = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PREDICTOR_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZIGZAG_ENABLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_BIAS  = 3'd5;

  // Predictor codes; the unused code behaves as Lorenzo 2D
  localparam logic [1:0] PRED_LORENZO = 2'd0;
  localparam logic [1:0] PRED_DIFF_X  = 2'd1;
  localparam logic [1:0] PRED_DIFF_Y  = 2'd2;

  function automatic logic [SAMPLE_W-1:0] sample_mask(input logic wide);
    return wide ? MASK16 : MASK8;
  endfunction

  // Zigzag-decode (optional) and add the bias, wrapped to the sample width
  function automatic logic [SAMPLE_W-1:0] decode_residual(
    input logic [CODE_W-1:0]   code,
    input logic                wide,
    input logic                zigzag,
    input logic [SAMPLE_W-1:0] bias
  );
    logic [SAMPLE_W-1:0] mask;
    logic [SAMPLE_W-1:0] z;
    logic [SAMPLE_W-1:0] d;
    mask = sample_mask(wide);
    z = code & mask;
    d = zigzag ? (((z >> 1) ^ {SAMPLE_W{z[0]}}) & mask) : z;
    return (d + bias) & mask;
  endfunction

  // Sign-extend from the sample width
  function automatic logic [SAMPLE_W-1:0] extend_sample(
    input logic [SAMPLE_W-1:0] v,
    input logic                wide
  );
    return wide ? v : {{(SAMPLE_W-8){v[7]}}, v[7:0]};
  endfunction

endpackage

// ===== rtl/tip_ram.sv =====
module tip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tile_inverse_predictor.sv =====
// Inverse Lorenzo / difference predictor for one tile in raster order. The block takes one
// residual code per cycle unless code_stall holds it, and returns one reconstructed sample
// per code, sign-extended to 16 bits, with tile_done on the tile's last pixel. When a code
// is taken, the row store read (the value above) is registered together with the code in
// the pixel stage; when the pixel stage fires, the decode and predictor add load the result
// register that drives value. Requests flow back to back while the output does not stall; a
// write to the same row store entry by the previous pixel (one-pixel rows) is forwarded.
// Configuration must be written only while the block is idle (the block does not enforce
// this); the row store is not cleared, so keep tile_width fixed within a tile.
module tile_inverse_predictor #(
  parameter int MAX_TILE_WIDTH = tip_pkg::TIP_MAX_TILE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data,
  // Residual codes
  input  logic                              code_valid,
  output logic                              code_stall,
  input  logic [tip_pkg::CODE_W-1:0]        code,
  // Reconstructed samples
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [tip_pkg::SAMPLE_W-1:0] value,
  output logic                              tile_done
);

  import tip_pkg::*;

  localparam int CW = $clog2(MAX_TILE_WIDTH);
  localparam int EW = $clog2(MAX_TILE_WIDTH + 1);
  localparam int LW = (EW > 9) ? EW : 9;

  // Configuration registers
  logic [8:0]          tile_width;
  logic [15:0]         tile_height;
  logic                wide_samples;
  logic [1:0]          predictor_mode;
  logic                zigzag_enable;
  logic [SAMPLE_W-1:0] residual_bias;

  // Raster position
  logic [CW-1:0]       column_count;
  logic [15:0]         row_count;

  // Pixel stage
  logic                s1_valid;
  logic [CODE_W-1:0]   s1_code;
  logic [CW-1:0]       s1_col;
  logic                s1_col_first;
  logic                s1_row_first;
  logic                s1_last_col;
  logic                s1_last_row;
  logic                fwd_hit;
  logic [SAMPLE_W-1:0] fwd_value;

  // Neighbor state
  logic [SAMPLE_W-1:0] left_value;
  logic [SAMPLE_W-1:0] upper_left_value;

  logic                code_accept;
  logic                s1_fire;
  logic [LW-1:0]       width_ext;
  logic [LW-1:0]       width_eff;
  logic [CW-1:0]       width_m1;
  logic [15:0]         height_m1;
  logic [CW-1:0]       col;
  logic                last_col;
  logic                last_row;
  logic [SAMPLE_W-1:0] ram_rd_data;
  logic [SAMPLE_W-1:0] n;
  logic [SAMPLE_W-1:0] wv;
  logic [SAMPLE_W-1:0] nw;
  logic [SAMPLE_W-1:0] a;
  logic [SAMPLE_W-1:0] sum;
  logic [SAMPLE_W-1:0] v;

  assign cfg_ready = 1'b1;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width     <= 9'd64;
      tile_height    <= 16'd64;
      wide_samples   <= 1'b1;
      predictor_mode <= PRED_LORENZO;
      zigzag_enable  <= 1'b1;
      residual_bias  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILE_WIDTH:     tile_width     <= cfg_data[8:0];
        REG_TILE_HEIGHT:    tile_height    <= cfg_data;
        REG_WIDE_SAMPLES:   wide_samples   <= cfg_data[0];
        REG_PREDICTOR_MODE: predictor_mode <= cfg_data[1:0];
        REG_ZIGZAG_ENABLE:  zigzag_enable  <= cfg_data[0];
        REG_RESIDUAL_BIAS:  residual_bias  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the pixel stage drains into the result register
  assign s1_fire     = s1_valid && (!result_valid || !result_stall);
  assign code_stall  = s1_valid && !s1_fire;
  assign code_accept = code_valid && !code_stall;

  // Clamp width and height, locate the incoming pixel
  always_comb begin
    width_ext = LW'(tile_width);
    if (width_ext == '0) begin
      width_eff = LW'(1);
    end else if (width_ext > LW'(MAX_TILE_WIDTH)) begin
      width_eff = LW'(MAX_TILE_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    width_m1  = CW'(width_eff - LW'(1));
    height_m1 = (tile_height == 16'd0) ? 16'd0 : tile_height - 16'd1;
    col       = (column_count > width_m1) ? width_m1 : column_count;
    last_col  = (col == width_m1);
    last_row  = (row_count >= height_m1);
  end

  // Advance the raster position on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (code_accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? 16'd0 : row_count + 16'd1;
      end else begin
        column_count <= col + CW'(1);
      end
    end
  end

  // Load the pixel stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (code_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (code_accept) begin
      s1_code      <= code;
      s1_col       <= col;
      s1_col_first <= (col == '0);
      s1_row_first <= (row_count == 16'd0);
      s1_last_col  <= last_col;
      s1_last_row  <= last_row;
      fwd_hit      <= s1_fire && (s1_col == col);
      fwd_value    <= v;
    end
  end

  // Row store: one entry per column, read ahead for the incoming pixel
  tip_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_TILE_WIDTH)
  ) u_row_above (
    .clk     (clk),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_data (v),
    .rd_en   (code_accept),
    .rd_addr (col),
    .rd_data (ram_rd_data)
  );

  // Gather neighbors; outside the tile they are zero
  always_comb begin
    n  = s1_row_first ? '0 : (fwd_hit ? fwd_value : ram_rd_data);
    wv = s1_col_first ? '0 : left_value;
    nw = (s1_row_first || s1_col_first) ? '0 : upper_left_value;
    a  = decode_residual(s1_code, wide_samples, zigzag_enable, residual_bias);
  end

  // Invert the predictor
  always_comb begin
    case (predictor_mode)
      PRED_DIFF_X: sum = a + wv;
      PRED_DIFF_Y: sum = a + n;
      default:     sum = a + n + wv - nw;
    endcase
    v = sum & sample_mask(wide_samples);
  end

  // Carry neighbors along the row, drop them at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      left_value       <= '0;
      upper_left_value <= '0;
    end else if (s1_fire) begin
      left_value       <= s1_last_col ? '0 : v;
      upper_left_value <= s1_last_col ? '0 : n;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      value     <= extend_sample(v, wide_samples);
      tile_done <= s1_last_col && s1_last_row;
    end
  end

endmodule
